FILE: hdl/tsqa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsqa_pkg;

  localparam int CoordW      = 32;
  localparam int DiffW       = 33;
  localparam int ProdW       = 66;
  localparam int AccW        = 67;
  localparam int MagW        = 66;
  localparam int NormBits    = 40;
  localparam int XyW         = 44;
  localparam int AngW        = 24;
  localparam int QualW       = 16;
  localparam int SumW        = 36;
  localparam int CntW        = 21;
  localparam int DivW        = 37;
  localparam int CordicSteps = 21;
  localparam int StepW       = 5;
  localparam int DivCntW     = 6;
  localparam int MulSteps    = 6;

  localparam logic [CntW-1:0]  MAX_TRIANGLES = CntW'(1048576);
  localparam logic [QualW-1:0] QUAL_ONE      = QualW'(32768);
  localparam int SixtyU       = 1048576;
  localparam int HalfTurnU    = 3145728;
  localparam int QuarterTurnU = 1572864;

  typedef struct packed {
    logic signed [AccW-1:0] k;
    logic signed [AccW-1:0] dot_a;
    logic signed [AccW-1:0] dot_b;
    logic                   inv;
    logic                   last;
  } tri_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NORM,
    B_ROT,
    B_QUAL,
    B_ACC,
    B_DIV,
    B_OUT
  } back_state_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = AngW'(786432);
      5'd1:  v = AngW'(464258);
      5'd2:  v = AngW'(245301);
      5'd3:  v = AngW'(124519);
      5'd4:  v = AngW'(62501);
      5'd5:  v = AngW'(31281);
      5'd6:  v = AngW'(15644);
      5'd7:  v = AngW'(7823);
      5'd8:  v = AngW'(3911);
      5'd9:  v = AngW'(1956);
      5'd10: v = AngW'(978);
      5'd11: v = AngW'(489);
      5'd12: v = AngW'(244);
      5'd13: v = AngW'(122);
      5'd14: v = AngW'(61);
      5'd15: v = AngW'(31);
      5'd16: v = AngW'(15);
      5'd17: v = AngW'(8);
      5'd18: v = AngW'(4);
      5'd19: v = AngW'(2);
      5'd20: v = AngW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/triangle_skew_quality_accumulator.sv
// flow: the front forms differences and products and pushes one item per triangle to the
// queue; the back normalizes and rotates once per angle, then computes quality, accumulates
// and outputs, and the last triangle also runs the mean divide. The back takes a new triangle
// only once its previous result is in the output register, as the normalizer and cordic are
// shared; inverted triangles skip the angle work. The front accepts only while idle (full low).
// reset: synchronous active-low rst_n clears queue, sum and count, sets minimum to one
`timescale 1ns / 1ps
`default_nettype none
module triangle_skew_quality_accumulator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_ax,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_ay,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_bx,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_by_coord,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_cx_coord,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]  in_cy_coord,
  input  wire logic                                in_last_tri,
  input  wire logic                                push,
  output logic                                     full,
  output logic [tsqa_pkg::QualW-1:0]               out_tri_quality,
  output logic                                     out_inverted,
  output logic [tsqa_pkg::QualW-1:0]               out_mean_quality,
  output logic [tsqa_pkg::QualW-1:0]               out_min_quality,
  output logic                                     out_done_res,
  output logic                                     empty,
  input  wire logic                                pop
);

  tsqa_pkg::tri_item_t f_item, b_item;
  logic f_valid, f_ready, b_valid, b_ready;

  tsqa_front u_front (
    .clk, .rst_n,
    .in_ax, .in_ay, .in_bx, .in_by_coord, .in_cx_coord, .in_cy_coord, .in_last_tri,
    .push, .full,
    .item_o(f_item), .item_valid_o(f_valid), .item_ready_i(f_ready)
  );

  tsqa_queue u_queue (
    .clk, .rst_n,
    .wr_item_i(f_item), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_item_o(b_item), .rd_valid_o(b_valid), .rd_ready_i(b_ready)
  );

  tsqa_back u_back (
    .clk, .rst_n,
    .item_i(b_item), .item_valid_i(b_valid), .item_ready_o(b_ready),
    .out_tri_quality, .out_inverted, .out_mean_quality, .out_min_quality, .out_done_res,
    .empty, .pop
  );

endmodule
`default_nettype wire

FILE: hdl/tsqa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tsqa_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_ax,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_ay,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_bx,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_by_coord,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_cx_coord,
  input  wire logic signed [tsqa_pkg::CoordW-1:0]    in_cy_coord,
  input  wire logic                                  in_last_tri,
  input  wire logic                                  push,
  output logic                                       full,
  output tsqa_pkg::tri_item_t                        item_o,
  output logic                                       item_valid_o,
  input  wire logic                                  item_ready_i
);

  tsqa_pkg::front_state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic signed [tsqa_pkg::DiffW-1:0] ux_r, uy_r, wx_r, wy_r, rx_r, ry_r;
  logic signed [tsqa_pkg::ProdW-1:0] prod_r, prod_w;
  logic signed [tsqa_pkg::AccW-1:0]  k_r, da_r, db_r, prod_ext;
  logic signed [tsqa_pkg::DiffW-1:0] ma, mb;
  logic last_r;
  logic accept;

  assign accept   = push && !full;
  assign prod_ext = tsqa_pkg::AccW'(prod_r);
  assign prod_w   = ma * mb;

  always_comb begin
    ma = ux_r;
    mb = wy_r;
    case (step_r)
      3'd0: begin ma = ux_r; mb = wy_r; end
      3'd1: begin ma = uy_r; mb = wx_r; end
      3'd2: begin ma = ux_r; mb = wx_r; end
      3'd3: begin ma = uy_r; mb = wy_r; end
      3'd4: begin ma = ux_r; mb = rx_r; end
      3'd5: begin ma = uy_r; mb = ry_r; end
      default: begin ma = ux_r; mb = wy_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      tsqa_pkg::F_IDLE: begin
        step_nxt = '0;
        if (accept) state_nxt = tsqa_pkg::F_MUL;
      end
      tsqa_pkg::F_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(tsqa_pkg::MulSteps)) state_nxt = tsqa_pkg::F_PUSH;
      end
      tsqa_pkg::F_PUSH: begin
        if (item_ready_i) state_nxt = tsqa_pkg::F_IDLE;
      end
      default: state_nxt = tsqa_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full         = (state_r != tsqa_pkg::F_IDLE);
    item_valid_o = (state_r == tsqa_pkg::F_PUSH);
    item_o.k     = k_r;
    item_o.dot_a = da_r;
    item_o.dot_b = db_r;
    item_o.inv   = k_r[tsqa_pkg::AccW-1] || (k_r == '0);
    item_o.last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsqa_pkg::F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // differences, products and sums
  always_ff @(posedge clk) begin
    if (accept) begin
      ux_r   <= tsqa_pkg::DiffW'(in_bx) - tsqa_pkg::DiffW'(in_ax);
      uy_r   <= tsqa_pkg::DiffW'(in_by_coord) - tsqa_pkg::DiffW'(in_ay);
      wx_r   <= tsqa_pkg::DiffW'(in_cx_coord) - tsqa_pkg::DiffW'(in_ax);
      wy_r   <= tsqa_pkg::DiffW'(in_cy_coord) - tsqa_pkg::DiffW'(in_ay);
      rx_r   <= tsqa_pkg::DiffW'(in_cx_coord) - tsqa_pkg::DiffW'(in_bx);
      ry_r   <= tsqa_pkg::DiffW'(in_cy_coord) - tsqa_pkg::DiffW'(in_by_coord);
      last_r <= in_last_tri;
    end
    if (state_r == tsqa_pkg::F_MUL) begin
      prod_r <= prod_w;
      case (step_r)
        3'd1: k_r  <= prod_ext;
        3'd2: k_r  <= k_r - prod_ext;
        3'd3: da_r <= prod_ext;
        3'd4: da_r <= da_r + prod_ext;
        3'd5: db_r <= -prod_ext;
        3'd6: db_r <= db_r - prod_ext;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tsqa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tsqa_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tsqa_pkg::tri_item_t  wr_item_i,
  input  wire logic                 wr_valid_i,
  output logic                      wr_ready_o,
  output tsqa_pkg::tri_item_t       rd_item_o,
  output logic                      rd_valid_o,
  input  wire logic                 rd_ready_i
);

  tsqa_pkg::tri_item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready_o = (cnt_r != 2'd2);
  assign rd_valid_o = (cnt_r != 2'd0);
  assign rd_item_o  = mem_r[rp_r];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item_i;
  end

endmodule
`default_nettype wire

FILE: hdl/tsqa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tsqa_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tsqa_pkg::tri_item_t           item_i,
  input  wire logic                          item_valid_i,
  output logic                               item_ready_o,
  output logic [tsqa_pkg::QualW-1:0]         out_tri_quality,
  output logic                               out_inverted,
  output logic [tsqa_pkg::QualW-1:0]         out_mean_quality,
  output logic [tsqa_pkg::QualW-1:0]         out_min_quality,
  output logic                               out_done_res,
  output logic                               empty,
  input  wire logic                          pop
);

  tsqa_pkg::back_state_t state_r, state_nxt;
  tsqa_pkg::tri_item_t   cur_r;
  logic sel_r;
  logic [tsqa_pkg::MagW-1:0] mk_r, md_r, or_w, mag_a, mag_b;
  logic neg_r;
  logic signed [tsqa_pkg::XyW-1:0]  x_r, y_r, xs, ys;
  logic signed [tsqa_pkg::AngW-1:0] z_r, a0_r, atan_w;
  logic [tsqa_pkg::StepW-1:0] i_r;
  logic [tsqa_pkg::QualW-1:0] q_r, q_w;
  logic [tsqa_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [tsqa_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [tsqa_pkg::QualW-1:0] min_r, min_nxt, min_hold_r;
  logic [tsqa_pkg::DivW-1:0] num_r;
  logic [tsqa_pkg::CntW-1:0] den_r;
  logic [tsqa_pkg::CntW:0]   rem_r, rem_sh;
  logic [tsqa_pkg::DivCntW-1:0] dcnt_r;
  logic out_valid_r, out_free;
  logic norm_done, rot_last, div_last;
  logic signed [27:0] a0e, a1e, a2e, amax, amin, t1, t2, tm, qq;
  logic signed [tsqa_pkg::AccW-1:0] dot_neg_a, dot_neg_b;

  assign out_free  = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign or_w      = mk_r | md_r;
  assign norm_done = !(|or_w[tsqa_pkg::MagW-1:tsqa_pkg::NormBits]) && or_w[tsqa_pkg::NormBits-1];
  assign rot_last  = (i_r == tsqa_pkg::StepW'(tsqa_pkg::CordicSteps - 1));
  assign div_last  = (dcnt_r == tsqa_pkg::DivCntW'(tsqa_pkg::DivW - 1));
  assign xs        = x_r >>> i_r;
  assign ys        = y_r >>> i_r;
  assign atan_w    = tsqa_pkg::atan_lut(i_r);
  assign dot_neg_a = -cur_r.dot_a;
  assign dot_neg_b = -cur_r.dot_b;
  assign mag_a = cur_r.dot_a[tsqa_pkg::AccW-1] ? dot_neg_a[tsqa_pkg::MagW-1:0]
                                               : cur_r.dot_a[tsqa_pkg::MagW-1:0];
  assign mag_b = cur_r.dot_b[tsqa_pkg::AccW-1] ? dot_neg_b[tsqa_pkg::MagW-1:0]
                                               : cur_r.dot_b[tsqa_pkg::MagW-1:0];
  assign rem_sh = {rem_r[tsqa_pkg::CntW-1:0], num_r[tsqa_pkg::DivW-1]};

  // quality from the three angles
  always_comb begin
    a0e  = 28'(a0_r);
    a1e  = 28'(z_r);
    a2e  = 28'(tsqa_pkg::HalfTurnU) - a0e - a1e;
    amax = a0e;
    amin = a0e;
    if (a1e > amax) amax = a1e;
    if (a2e > amax) amax = a2e;
    if (a1e < amin) amin = a1e;
    if (a2e < amin) amin = a2e;
    t1 = (amax - 28'(tsqa_pkg::SixtyU) + 28'sd32) >>> 6;
    t2 = (28'(tsqa_pkg::SixtyU) - amin + 28'sd16) >>> 5;
    tm = (t1 > t2) ? t1 : t2;
    qq = 28'sd32768 - tm;
    if (qq < 0) q_w = '0;
    else if (qq > 28'sd32768) q_w = tsqa_pkg::QUAL_ONE;
    else q_w = qq[tsqa_pkg::QualW-1:0];
  end

  always_comb begin
    if (cnt_r < tsqa_pkg::MAX_TRIANGLES) begin
      sum_nxt = sum_r + tsqa_pkg::SumW'(q_r);
      cnt_nxt = cnt_r + tsqa_pkg::CntW'(1);
    end else begin
      sum_nxt = sum_r;
      cnt_nxt = cnt_r;
    end
    min_nxt = (q_r < min_r) ? q_r : min_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsqa_pkg::B_IDLE:
        if (item_valid_i) state_nxt = item_i.inv ? tsqa_pkg::B_ACC : tsqa_pkg::B_NORM;
      tsqa_pkg::B_NORM: if (norm_done) state_nxt = tsqa_pkg::B_ROT;
      tsqa_pkg::B_ROT:
        if (rot_last) state_nxt = sel_r ? tsqa_pkg::B_QUAL : tsqa_pkg::B_NORM;
      tsqa_pkg::B_QUAL: state_nxt = tsqa_pkg::B_ACC;
      tsqa_pkg::B_ACC:  state_nxt = cur_r.last ? tsqa_pkg::B_DIV : tsqa_pkg::B_OUT;
      tsqa_pkg::B_DIV:  if (div_last) state_nxt = tsqa_pkg::B_OUT;
      tsqa_pkg::B_OUT:  if (out_free) state_nxt = tsqa_pkg::B_IDLE;
      default: state_nxt = tsqa_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = (state_r == tsqa_pkg::B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsqa_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      min_r       <= tsqa_pkg::QUAL_ONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == tsqa_pkg::B_OUT && out_free) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
      if (state_r == tsqa_pkg::B_ACC) begin
        if (cur_r.last) begin
          sum_r <= '0;
          cnt_r <= '0;
          min_r <= tsqa_pkg::QUAL_ONE;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
          min_r <= min_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tsqa_pkg::B_IDLE: begin
        cur_r <= item_i;
        sel_r <= 1'b0;
        q_r   <= '0;
        mk_r  <= item_i.k[tsqa_pkg::MagW-1:0];
        neg_r <= item_i.dot_a[tsqa_pkg::AccW-1];
        md_r  <= item_i.dot_a[tsqa_pkg::AccW-1] ?
                 ((~item_i.dot_a[tsqa_pkg::MagW-1:0]) + tsqa_pkg::MagW'(1)) :
                 item_i.dot_a[tsqa_pkg::MagW-1:0];
      end
      tsqa_pkg::B_NORM: begin
        i_r <= '0;
        if (|or_w[tsqa_pkg::MagW-1:tsqa_pkg::NormBits]) begin
          mk_r <= mk_r >> 1;
          md_r <= md_r >> 1;
        end else if (!or_w[tsqa_pkg::NormBits-1]) begin
          mk_r <= mk_r << 1;
          md_r <= md_r << 1;
        end else if (neg_r) begin
          x_r <= tsqa_pkg::XyW'(mk_r[tsqa_pkg::NormBits-1:0]);
          y_r <= tsqa_pkg::XyW'(md_r[tsqa_pkg::NormBits-1:0]);
          z_r <= tsqa_pkg::AngW'(tsqa_pkg::QuarterTurnU);
        end else begin
          x_r <= tsqa_pkg::XyW'(md_r[tsqa_pkg::NormBits-1:0]);
          y_r <= tsqa_pkg::XyW'(mk_r[tsqa_pkg::NormBits-1:0]);
          z_r <= '0;
        end
      end
      tsqa_pkg::B_ROT: begin
        i_r <= i_r + tsqa_pkg::StepW'(1);
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_w;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_w;
        end
        if (rot_last && !sel_r) begin
          a0_r  <= (y_r > 0) ? z_r + atan_w : z_r - atan_w;
          sel_r <= 1'b1;
          mk_r  <= cur_r.k[tsqa_pkg::MagW-1:0];
          md_r  <= mag_b;
          neg_r <= cur_r.dot_b[tsqa_pkg::AccW-1];
        end
      end
      tsqa_pkg::B_QUAL: q_r <= q_w;
      tsqa_pkg::B_ACC: begin
        num_r      <= tsqa_pkg::DivW'(sum_nxt) + tsqa_pkg::DivW'(cnt_nxt >> 1);
        den_r      <= cnt_nxt;
        min_hold_r <= min_nxt;
        rem_r      <= '0;
        dcnt_r     <= '0;
      end
      tsqa_pkg::B_DIV: begin
        dcnt_r <= dcnt_r + tsqa_pkg::DivCntW'(1);
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          num_r <= {num_r[tsqa_pkg::DivW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[tsqa_pkg::DivW-2:0], 1'b0};
        end
      end
      tsqa_pkg::B_OUT: begin
        if (out_free) begin
          out_tri_quality  <= q_r;
          out_inverted     <= cur_r.inv;
          out_done_res     <= cur_r.last;
          out_mean_quality <= (cur_r.last && den_r != '0) ? num_r[tsqa_pkg::QualW-1:0] : '0;
          out_min_quality  <= cur_r.last ? min_hold_r : '0;
        end
      end
      default: ;
    endcase
  end

  // mag_a is the same magnitude the idle load computes for the first angle
  a_load_mag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tsqa_pkg::B_NORM && !sel_r && $past(state_r) == tsqa_pkg::B_IDLE
    |-> md_r == mag_a)
    else $error("first angle magnitude mismatch");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_inverted |-> out_tri_quality == '0)
    else $error("inverted triangle with nonzero quality");
  a_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_done_res |-> out_mean_quality == '0 && out_min_quality == '0)
    else $error("totals shown before last triangle");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tsqa_pkg::MAX_TRIANGLES)
    else $error("triangle count beyond limit");
  a_qual_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tsqa_pkg::B_ACC |-> q_r <= tsqa_pkg::QUAL_ONE)
    else $error("quality above one");

endmodule
`default_nettype wire
